// ===== hdl/psa_pkg.sv =====
// Shared constants for the PID step controller with anti-windup.
`default_nettype none
package psa_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEGRAL_GAIN = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_UPPER     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_LOWER     = 3'd4;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/psa_fifo.sv =====
// Small synchronous queue of register entries.
`default_nettype none
module psa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             wdata,
   output logic                              full,
   input  wire logic                         pop,
   output logic [WIDTH-1:0]                  rdata,
   output logic                              empty,
   output logic [$clog2(DEPTH+1)-1:0]        count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/psa_front.sv =====
// Front end: takes requests, forms the error terms and tracks the previous error.
`default_nettype none
module psa_front #(
   parameter int DATA_WIDTH = psa_pkg::DATA_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   output logic                              full,
   input  wire logic                         req_action,
   input  wire logic signed [DATA_WIDTH-1:0] req_setpoint,
   input  wire logic signed [DATA_WIDTH-1:0] req_measured,
   output logic                              q_push,
   output logic [3*DATA_WIDTH:0]             q_data,
   input  wire logic                         q_full
);

   localparam int DW = DATA_WIDTH;
   localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

   function automatic logic signed [DW-1:0] sat1(input logic signed [DW:0] v);
      logic signed [DW-1:0] r;
      if (v[DW] != v[DW-1]) r = v[DW] ? SMIN : SMAX;
      else                  r = v[DW-1:0];
      return r;
   endfunction

   logic signed [DW-1:0] last_error_ff, last_error_in;
   logic signed [DW-1:0] err, esum, ediff;
   logic                 accept, is_clear;

   assign full     = q_full;
   assign accept   = push && !q_full;
   assign is_clear = (req_action == psa_pkg::ACT_CLEAR);

   always_comb begin
      err   = sat1({req_setpoint[DW-1], req_setpoint} - {req_measured[DW-1], req_measured});
      esum  = sat1({err[DW-1], err} + {last_error_ff[DW-1], last_error_ff});
      ediff = sat1({err[DW-1], err} - {last_error_ff[DW-1], last_error_ff});
      last_error_in = last_error_ff;
      if (accept) begin
         last_error_in = is_clear ? '0 : err;
      end
   end

   assign q_push = accept;
   assign q_data = {is_clear, err, esum, ediff};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
      end else begin
         last_error_ff <= last_error_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/psa_back.sv =====
// Back end: gain products, clamped integrator, derivative and output limiting.
`default_nettype none
module psa_back #(
   parameter int DATA_WIDTH = psa_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = psa_pkg::FRAC_BITS,
   parameter int OUT_DEPTH  = psa_pkg::OUT_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             mid_empty,
   input  wire logic [3*DATA_WIDTH:0]            mid_data,
   output logic                                  mid_pop,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
   output logic                                  out_push,
   output logic signed [DATA_WIDTH-1:0]          out_drive,
   input  wire logic [DATA_WIDTH-2:0]            prop_gain,
   input  wire logic [DATA_WIDTH-2:0]            integral_gain,
   input  wire logic [DATA_WIDTH-2:0]            deriv_gain,
   input  wire logic signed [DATA_WIDTH-1:0]     out_upper,
   input  wire logic signed [DATA_WIDTH-1:0]     out_lower
);

   localparam int DW = DATA_WIDTH;
   localparam int CW = $clog2(OUT_DEPTH+1);
   localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

   function automatic logic signed [DW-1:0] sat1(input logic signed [DW:0] v);
      logic signed [DW-1:0] r;
      if (v[DW] != v[DW-1]) r = v[DW] ? SMIN : SMAX;
      else                  r = v[DW-1:0];
      return r;
   endfunction

   function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      return sat1({a[DW-1], a} + {b[DW-1], b});
   endfunction

   function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      return sat1({a[DW-1], a} - {b[DW-1], b});
   endfunction

   // floor(x * g / 2^FRAC_BITS), saturated
   function automatic logic signed [DW-1:0] mulg(input logic signed [DW-1:0] x,
                                                 input logic [DW-2:0] g);
      logic signed [2*DW-1:0] p;
      logic signed [2*DW-1:0] s;
      logic signed [DW-1:0]   r;
      p = x * $signed({1'b0, g});
      s = p >>> FRAC_BITS;
      if ((&s[2*DW-1:DW-1]) || !(|s[2*DW-1:DW-1])) r = s[DW-1:0];
      else                                          r = s[2*DW-1] ? SMIN : SMAX;
      return r;
   endfunction

   logic                 mid_clr;
   logic signed [DW-1:0] mid_err, mid_esum, mid_ediff;
   logic [CW:0]          in_flight;

   logic                 v1_ff, clr1_ff;
   logic signed [DW-1:0] prop1_ff, mi1_ff, md1_ff;

   logic signed [DW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] ld_ff, ld_in;
   logic signed [DW-1:0] integ_raw, hi_int, lo_int, integ, deriv;

   logic                 v2_ff, clr2_ff;
   logic signed [DW-1:0] prop2_ff, integ2_ff, deriv2_ff;
   logic signed [DW-1:0] total, limited;

   assign {mid_clr, mid_err, mid_esum, mid_ediff} = mid_data;

   // results in the pipe plus those queued must leave room for one more
   assign in_flight = {1'b0, out_count} + (CW+1)'(v1_ff) + (CW+1)'(v2_ff);
   assign mid_pop   = !mid_empty && (in_flight < (CW+1)'(OUT_DEPTH));

   // stage 1: gain products
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      clr1_ff  <= mid_clr;
      prop1_ff <= mulg(mid_err, prop_gain);
      mi1_ff   <= mulg(mid_esum, integral_gain);
      md1_ff   <= mulg(mid_ediff, deriv_gain);
   end

   // stage 2: integrator with anti-windup, derivative
   always_comb begin
      integ_raw = sadd(acc_ff, mi1_ff);
      hi_int    = (out_upper > prop1_ff) ? ssub(out_upper, prop1_ff) : '0;
      lo_int    = (out_lower < prop1_ff) ? ssub(out_lower, prop1_ff) : '0;
      if (integ_raw > hi_int)      integ = hi_int;
      else if (integ_raw < lo_int) integ = lo_int;
      else                         integ = integ_raw;
      deriv  = ssub(md1_ff, ld_ff);
      acc_in = acc_ff;
      ld_in  = ld_ff;
      if (v1_ff) begin
         acc_in = clr1_ff ? '0 : integ;
         ld_in  = clr1_ff ? '0 : deriv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff  <= 1'b0;
         acc_ff <= '0;
         ld_ff  <= '0;
      end else begin
         v2_ff  <= v1_ff;
         acc_ff <= acc_in;
         ld_ff  <= ld_in;
      end
   end

   always_ff @(posedge clock) begin
      clr2_ff   <= clr1_ff;
      prop2_ff  <= prop1_ff;
      integ2_ff <= integ;
      deriv2_ff <= deriv;
   end

   // stage 3: sum and output limits, written into the result queue
   always_comb begin
      total = sadd(sadd(prop2_ff, integ2_ff), deriv2_ff);
      if (total > out_upper)      limited = out_upper;
      else if (total < out_lower) limited = out_lower;
      else                        limited = total;
   end

   assign out_push  = v2_ff;
   assign out_drive = clr2_ff ? '0 : limited;

endmodule
`default_nettype wire

// ===== hdl/pid_step_antiwindup.sv =====
// Top level of the PID step controller with trapezoidal integral and anti-windup.
// Path: request queue, gain-product registers, integrator registers, then the output queue.
// Throughput: one request per cycle while the output queue has room (single-pass integrator/derivative).
// Results wait in a 4-entry output queue; requests in a 2-entry queue ahead of the back end.
// Reset (synchronous): empties both queues, zeroes the loop state, gains to 0, limits to full range.
`default_nettype none
module pid_step_antiwindup #(
   parameter int DATA_WIDTH = psa_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = psa_pkg::FRAC_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic                                  req_action,
   input  wire logic signed [DATA_WIDTH-1:0]          req_setpoint,
   input  wire logic signed [DATA_WIDTH-1:0]          req_measured,
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic signed [DATA_WIDTH-1:0]               rsp_drive,
   input  wire logic                                  csr_we,
   input  wire logic [psa_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [DATA_WIDTH-1:0]                 csr_wdata
);

   localparam int DW  = DATA_WIDTH;
   localparam int QW  = 3*DW + 1;
   localparam int OCW = $clog2(psa_pkg::OUT_DEPTH+1);

   logic [DW-2:0]        prop_gain_ff, integral_gain_ff, deriv_gain_ff;
   logic signed [DW-1:0] out_upper_ff, out_lower_ff;

   logic                 q_push, q_full, mid_empty, mid_pop;
   logic [QW-1:0]        q_data, mid_data;
   logic                 out_push;
   logic signed [DW-1:0] out_drive;
   logic [OCW-1:0]       out_count;
   logic [DW-1:0]        rsp_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_gain_ff <= '0;
         deriv_gain_ff    <= '0;
         out_upper_ff     <= {1'b0, {(DW-1){1'b1}}};
         out_lower_ff     <= {1'b1, {(DW-1){1'b0}}};
      end else if (csr_we) begin
         case (csr_index)
            psa_pkg::REG_PROP_GAIN:     prop_gain_ff     <= csr_wdata[DW-2:0];
            psa_pkg::REG_INTEGRAL_GAIN: integral_gain_ff <= csr_wdata[DW-2:0];
            psa_pkg::REG_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata[DW-2:0];
            psa_pkg::REG_OUT_UPPER:     out_upper_ff     <= csr_wdata;
            psa_pkg::REG_OUT_LOWER:     out_lower_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   psa_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_action   (req_action),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .q_push       (q_push),
      .q_data       (q_data),
      .q_full       (q_full)
   );

   psa_fifo #(
      .WIDTH (QW),
      .DEPTH (psa_pkg::MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_data),
      .full  (q_full),
      .pop   (mid_pop),
      .rdata (mid_data),
      .empty (mid_empty),
      .count ()
   );

   psa_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .OUT_DEPTH  (psa_pkg::OUT_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .mid_empty     (mid_empty),
      .mid_data      (mid_data),
      .mid_pop       (mid_pop),
      .out_count     (out_count),
      .out_push      (out_push),
      .out_drive     (out_drive),
      .prop_gain     (prop_gain_ff),
      .integral_gain (integral_gain_ff),
      .deriv_gain    (deriv_gain_ff),
      .out_upper     (out_upper_ff),
      .out_lower     (out_lower_ff)
   );

   psa_fifo #(
      .WIDTH (DW),
      .DEPTH (psa_pkg::OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_drive),
      .full  (),
      .pop   (pop),
      .rdata (rsp_raw),
      .empty (empty),
      .count (out_count)
   );

   assign rsp_drive = $signed(rsp_raw);

endmodule
`default_nettype wire

// ===== dv/pid_step_antiwindup_test.sv =====
// Self-checking testbench for pid_step_antiwindup: queue-fed driver, result monitor, PID predictor.
`timescale 1ns / 1ps
module pid_step_antiwindup_test;

   typedef struct packed {
      logic                                  action;
      logic signed [psa_pkg::DATA_WIDTH-1:0] setpoint;
      logic signed [psa_pkg::DATA_WIDTH-1:0] measured;
   } sample_type;

   localparam longint DW_MAX = (longint'(1) <<< (psa_pkg::DATA_WIDTH - 1)) - 1;
   localparam longint DW_MIN = -DW_MAX - 1;
   localparam logic [psa_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
   localparam logic signed [psa_pkg::DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [psa_pkg::DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 110;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    push = 1'b0;
   logic                                    full;
   logic                                    req_action = psa_pkg::ACT_SAMPLE;
   logic signed [psa_pkg::DATA_WIDTH-1:0]   req_setpoint = '0;
   logic signed [psa_pkg::DATA_WIDTH-1:0]   req_measured = '0;
   logic                                    empty;
   logic                                    pop = 1'b0;
   logic signed [psa_pkg::DATA_WIDTH-1:0]   rsp_drive;
   logic                                    csr_we = 1'b0;
   logic [psa_pkg::CSR_INDEX_WIDTH-1:0]     csr_index = psa_pkg::REG_PROP_GAIN;
   logic [psa_pkg::DATA_WIDTH-1:0]          csr_wdata = '0;

   // predictor copy of the registers and loop state
   longint kp_gain = 0, ki_gain = 0, kd_gain = 0;
   longint lim_hi = DW_MAX, lim_lo = DW_MIN;
   longint integ_acc = 0, prev_err = 0, prev_deriv = 0;

   sample_type                            pending[$];
   logic signed [psa_pkg::DATA_WIDTH-1:0] drive_due[$];
   sample_type                            cur;
   int  gap_left = 0, stall_left = 0, hold_left = 0, hold_idx = 0;
   int  hold_at[2] = '{150, 800};
   bit  calm = 1'b0;
   int  sent = 0, clears = 0, checked = 0, errors = 0, csr_writes = 0, cycles = 0;

   pid_step_antiwindup i_dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_action   (req_action),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .empty        (empty),
      .pop          (pop),
      .rsp_drive    (rsp_drive),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint clip_dw(input longint v);
      if (v > DW_MAX) return DW_MAX;
      if (v < DW_MIN) return DW_MIN;
      return v;
   endfunction

   // floor of x * g / 2^FRAC_BITS, saturated
   function automatic longint gain_mul(input longint x, input longint g);
      longint p;
      p = x * g;
      return clip_dw(p >>> psa_pkg::FRAC_BITS);
   endfunction

   function automatic logic signed [psa_pkg::DATA_WIDTH-1:0] pid_predict(
         input sample_type s);
      longint err, prop, integ, hi_int, lo_int, deriv, res;
      if (s.action == psa_pkg::ACT_CLEAR) begin
         integ_acc = 0;
         prev_err = 0;
         prev_deriv = 0;
         return '0;
      end
      err = clip_dw(longint'(s.setpoint) - longint'(s.measured));
      prop = gain_mul(err, kp_gain);
      integ = clip_dw(integ_acc + gain_mul(clip_dw(err + prev_err), ki_gain));
      hi_int = (lim_hi > prop) ? clip_dw(lim_hi - prop) : 0;
      lo_int = (lim_lo < prop) ? clip_dw(lim_lo - prop) : 0;
      // upper bound wins when the limits are inverted
      if (integ > hi_int) begin
         integ = hi_int;
      end else if (integ < lo_int) begin
         integ = lo_int;
      end
      deriv = clip_dw(gain_mul(clip_dw(err - prev_err), kd_gain) - prev_deriv);
      res = clip_dw(clip_dw(prop + integ) + deriv);
      if (res > lim_hi) begin
         res = lim_hi;
      end else if (res < lim_lo) begin
         res = lim_lo;
      end
      integ_acc = integ;
      prev_deriv = deriv;
      prev_err = err;
      return res[psa_pkg::DATA_WIDTH-1:0];
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            drive_due.push_back(pid_predict(cur));
            sent++;
            if (cur.action == psa_pkg::ACT_CLEAR) clears++;
         end
         if (!push || !full) begin
            if (gap_left > 0) begin
               gap_left--;
               push <= 1'b0;
            end else if (pending.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 5);
               push <= 1'b0;
            end else if (pending.size() > 0) begin
               cur = pending.pop_front();
               req_action <= cur.action;
               req_setpoint <= cur.setpoint;
               req_measured <= cur.measured;
               push <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (drive_due.size() == 0) begin
               $display("%0t: unexpected transfer, drive %0d", $time, rsp_drive);
               errors++;
            end else begin
               if (rsp_drive !== drive_due[0]) begin
                  $display("%0t: drive mismatch, expected %0d, actual %0d",
                           $time, drive_due[0], rsp_drive);
                  errors++;
               end
               void'(drive_due.pop_front());
               checked++;
            end
         end
         // long hold-off so the block backs up and raises full
         if (hold_idx < 2 && checked >= hold_at[hold_idx]) begin
            hold_left = 160;
            hold_idx++;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 5);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, drive_due.size());
         $display("pid_step_antiwindup_test NOT OK");
         $finish;
      end
   end

   task automatic csr_write(input logic [psa_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [psa_pkg::DATA_WIDTH-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         psa_pkg::REG_PROP_GAIN:     kp_gain = longint'(val & 32'h7FFF_FFFF);
         psa_pkg::REG_INTEGRAL_GAIN: ki_gain = longint'(val & 32'h7FFF_FFFF);
         psa_pkg::REG_DERIV_GAIN:    kd_gain = longint'(val & 32'h7FFF_FFFF);
         psa_pkg::REG_OUT_UPPER:     lim_hi = longint'($signed(val));
         psa_pkg::REG_OUT_LOWER:     lim_lo = longint'($signed(val));
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_item(input logic act,
                           input logic signed [psa_pkg::DATA_WIDTH-1:0] sp,
                           input logic signed [psa_pkg::DATA_WIDTH-1:0] ms);
      sample_type s;
      s.action = act;
      s.setpoint = sp;
      s.measured = ms;
      pending.push_back(s);
   endtask

   // wait until every transfer is done and the pipeline has drained
   task automatic settle();
      do @(negedge clock);
      while (pending.size() > 0 || push || drive_due.size() > 0);
      repeat (6) @(negedge clock);
   endtask

   function automatic logic [psa_pkg::DATA_WIDTH-1:0] rand_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return $urandom;
         2:       return 32'h7FFF_FFFF;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   task automatic random_config();
      logic signed [psa_pkg::DATA_WIDTH-1:0] a, b;
      csr_write(psa_pkg::REG_PROP_GAIN, rand_gain());
      csr_write(psa_pkg::REG_INTEGRAL_GAIN, rand_gain());
      csr_write(psa_pkg::REG_DERIV_GAIN, rand_gain());
      a = $urandom_range(0, 32'h01FF_FFFF);
      b = $urandom_range(0, 32'h01FF_FFFF);
      case ($urandom_range(0, 5))
         0: begin a = VAL_MAX; b = VAL_MIN; end
         1: begin b = -a; end
         2: begin a = $urandom; b = $urandom; end
         3: begin b = a; end
         default: begin b = -b; end
      endcase
      csr_write(psa_pkg::REG_OUT_UPPER, a);
      csr_write(psa_pkg::REG_OUT_LOWER, b);
      if ($urandom_range(0, 3) == 0) csr_write(REG_UNUSED, $urandom);
   endtask

   function automatic logic signed [psa_pkg::DATA_WIDTH-1:0] edge_value();
      case ($urandom_range(0, 3))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return '0;
         default: return -1;
      endcase
   endfunction

   task automatic random_items(input int n);
      logic                                  act;
      logic signed [psa_pkg::DATA_WIDTH-1:0] sp, ms;
      for (int k = 0; k < n; k++) begin
         act = ($urandom_range(0, 15) == 0) ? psa_pkg::ACT_CLEAR : psa_pkg::ACT_SAMPLE;
         case ($urandom_range(0, 9))
            6, 7: begin
               sp = $urandom;
               ms = $urandom;
            end
            8: begin
               sp = edge_value();
               ms = edge_value();
            end
            9: begin
               sp = $urandom;
               ms = sp + $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
            end
            default: begin
               // tracking loop: measurement close to the setpoint
               sp = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
               ms = sp + $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
            end
         endcase
         add_item(act, sp, ms);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: zero gains give zero drive
      add_item(psa_pkg::ACT_SAMPLE, 32'sh0005_0000, 32'sh0001_0000);
      add_item(psa_pkg::ACT_SAMPLE, VAL_MAX, VAL_MIN);
      settle();

      csr_write(psa_pkg::REG_PROP_GAIN, 32'h0001_0000);
      csr_write(psa_pkg::REG_INTEGRAL_GAIN, 32'h0000_4000);
      csr_write(psa_pkg::REG_DERIV_GAIN, 32'h0000_8000);
      csr_write(psa_pkg::REG_OUT_UPPER, 32'h0064_0000);
      csr_write(psa_pkg::REG_OUT_LOWER, 32'hFF9C_0000);
      add_item(psa_pkg::ACT_SAMPLE, 32'sh0005_0000, '0);
      add_item(psa_pkg::ACT_SAMPLE, 32'sh0005_0000, 32'sh0001_0000);
      add_item(psa_pkg::ACT_SAMPLE, VAL_MAX, VAL_MIN);
      add_item(psa_pkg::ACT_SAMPLE, VAL_MIN, VAL_MAX);
      add_item(psa_pkg::ACT_SAMPLE, VAL_MAX, VAL_MAX);
      add_item(psa_pkg::ACT_SAMPLE, VAL_MIN, VAL_MIN);
      add_item(psa_pkg::ACT_CLEAR, 32'sh0001_0000, '0);
      add_item(psa_pkg::ACT_SAMPLE, -32'sh0003_0000, 32'sh0002_0000);
      add_item(psa_pkg::ACT_SAMPLE, '0, '0);
      settle();

      // gain registers drop bit 31; full-scale gains
      csr_write(psa_pkg::REG_PROP_GAIN, 32'hFFFF_FFFF);
      csr_write(psa_pkg::REG_INTEGRAL_GAIN, 32'h7FFF_FFFF);
      csr_write(psa_pkg::REG_DERIV_GAIN, 32'hFFFF_FFFF);
      csr_write(psa_pkg::REG_OUT_UPPER, VAL_MAX);
      csr_write(psa_pkg::REG_OUT_LOWER, VAL_MIN);
      csr_write(REG_UNUSED, 32'h1234_5678);
      add_item(psa_pkg::ACT_SAMPLE, VAL_MAX, '0);
      add_item(psa_pkg::ACT_SAMPLE, VAL_MIN, '0);
      add_item(psa_pkg::ACT_SAMPLE, 32'sh0000_0001, '0);
      add_item(psa_pkg::ACT_SAMPLE, -32'sh0000_0001, '0);
      add_item(psa_pkg::ACT_CLEAR, VAL_MIN, VAL_MAX);
      settle();

      // inverted limits
      csr_write(psa_pkg::REG_PROP_GAIN, 32'h0001_0000);
      csr_write(psa_pkg::REG_OUT_UPPER, 32'hFFF6_0000);
      csr_write(psa_pkg::REG_OUT_LOWER, 32'h000A_0000);
      add_item(psa_pkg::ACT_SAMPLE, '0, '0);
      add_item(psa_pkg::ACT_SAMPLE, 32'sh0032_0000, '0);
      add_item(psa_pkg::ACT_SAMPLE, -32'sh0032_0000, '0);
      add_item(psa_pkg::ACT_CLEAR, '0, '0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         random_config();
         if (p >= RANDOM_PHASES - 2) calm = 1'b1;
         random_items(PHASE_ITEMS);
      end
      settle();

      $display("Covered %0d requests (%0d clears) across %0d register writes;",
               sent, clears, csr_writes);
      $display("compared %0d results with %0d mismatches.", checked, errors);
      if (errors == 0) begin
         $display("pid_step_antiwindup_test OK");
      end else begin
         $display("pid_step_antiwindup_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== pid_step_antiwindup.f =====
hdl/psa_pkg.sv
hdl/psa_fifo.sv
hdl/psa_front.sv
hdl/psa_back.sv
hdl/pid_step_antiwindup.sv
dv/pid_step_antiwindup_test.sv
